// ===== rtl/mec_pkg.sv =====
// mec_pkg: widths, fixed-point constants and control types for the escape counter
// used by mec_ctrl, mec_datapath and the top level; no dependencies
package mec_pkg;

   // iteration counter width and fractional bits of the fixed-point format
   localparam int STEP_BITS = 16;
   localparam int FRAC_BITS = 27;

   // coordinate width, full product width, and width of a scaled sum
   localparam int Z_W    = 32;
   localparam int PROD_W = 2 * Z_W;
   localparam int SUM_W  = PROD_W - FRAC_BITS + 3;

   // box bounds in the scaled domain
   localparam longint RE_HI_L = 64'sd2 <<< FRAC_BITS;
   localparam longint IM_HI_L = 64'sd3 <<< (FRAC_BITS - 1);
   localparam logic signed [SUM_W-1:0] RE_HI = SUM_W'(RE_HI_L);
   localparam logic signed [SUM_W-1:0] RE_LO = SUM_W'(-RE_HI_L);
   localparam logic signed [SUM_W-1:0] IM_HI = SUM_W'(IM_HI_L);
   localparam logic signed [SUM_W-1:0] IM_LO = SUM_W'(-IM_HI_L);

   // reset value of the iteration limit
   localparam logic [STEP_BITS-1:0] MAX_STEPS_RESET = STEP_BITS'(20);

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;  // capture c and set z = c
      logic mul;   // register the three products
      logic acc;   // form the new z
   } dp_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic escape;  // new z lies outside the box
   } dp_status_type;

endpackage

// ===== rtl/mec_datapath.sv =====
// mec_datapath: point and z registers, product registers, next-z adders and box test
// depends on mec_pkg
module mec_datapath
   import mec_pkg::*;
(
   input  logic                  clock,
   input  dp_cmd_type            cmd,
   input  logic signed [Z_W-1:0] c_real,
   input  logic signed [Z_W-1:0] c_imag,
   output dp_status_type         status
);

   logic signed [Z_W-1:0]    c_re_ff;
   logic signed [Z_W-1:0]    c_im_ff;
   logic signed [Z_W-1:0]    z_re_ff;
   logic signed [Z_W-1:0]    z_im_ff;
   logic signed [Z_W-1:0]    z_re_in;
   logic signed [Z_W-1:0]    z_im_in;
   logic signed [PROD_W-1:0] prod_rr_ff;
   logic signed [PROD_W-1:0] prod_ii_ff;
   logic signed [PROD_W-1:0] prod_ri_ff;
   logic signed [SUM_W-1:0]  rr_s;
   logic signed [SUM_W-1:0]  ii_s;
   logic signed [SUM_W-1:0]  ri_s;
   logic signed [SUM_W-1:0]  new_re;
   logic signed [SUM_W-1:0]  new_im;

   // scale products back to the fixed-point format (floor)
   assign rr_s = SUM_W'(prod_rr_ff >>> FRAC_BITS);
   assign ii_s = SUM_W'(prod_ii_ff >>> FRAC_BITS);
   assign ri_s = SUM_W'(prod_ri_ff >>> FRAC_BITS);

   // next z
   assign new_re = rr_s - ii_s + SUM_W'(c_re_ff);
   assign new_im = (ri_s <<< 1) + SUM_W'(c_im_ff);

   // box test, bounds inclusive
   assign status.escape = (new_re < RE_LO) || (new_re > RE_HI) ||
                          (new_im < IM_LO) || (new_im > IM_HI);

   // z load or update; a z that stays is in the box and fits Z_W bits
   always_comb begin
      z_re_in = z_re_ff;
      z_im_in = z_im_ff;
      if (cmd.load) begin
         z_re_in = c_real;
         z_im_in = c_imag;
      end else if (cmd.acc) begin
         z_re_in = new_re[Z_W-1:0];
         z_im_in = new_im[Z_W-1:0];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         c_re_ff <= c_real;
         c_im_ff <= c_imag;
      end
      z_re_ff <= z_re_in;
      z_im_ff <= z_im_in;
      if (cmd.mul) begin
         prod_rr_ff <= z_re_ff * z_re_ff;
         prod_ii_ff <= z_im_ff * z_im_ff;
         prod_ri_ff <= z_re_ff * z_im_ff;
      end
   end

endmodule

// ===== rtl/mec_ctrl.sv =====
// mec_ctrl: sequencer, iteration counter, limit register and result register
// depends on mec_pkg
module mec_ctrl
   import mec_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [STEP_BITS-1:0] rsp_step_count,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [STEP_BITS-1:0] csr_max_steps,
   output dp_cmd_type           cmd,
   input  dp_status_type        status
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_ACC  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type            state_ff;
   state_type            state_in;
   logic [STEP_BITS-1:0] count_ff;
   logic [STEP_BITS-1:0] count_in;
   logic [STEP_BITS-1:0] count_inc;
   logic [STEP_BITS-1:0] max_steps_ff;
   logic [STEP_BITS-1:0] out_count_ff;
   logic                 out_valid_ff;
   logic                 out_valid_in;
   logic                 out_load;

   assign req_ready      = (state_ff == ST_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_valid      = out_valid_ff;
   assign rsp_step_count = out_count_ff;
   assign count_inc      = count_ff + STEP_BITS'(1);

   // sequencer
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      cmd      = '0;
      out_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               count_in = '0;
               state_in = (max_steps_ff == '0) ? ST_DONE : ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc = 1'b1;
            if (status.escape) begin
               state_in = ST_DONE;
            end else begin
               count_in = count_inc;
               state_in = (count_inc == max_steps_ff) ? ST_DONE : ST_MUL;
            end
         end
         ST_DONE: begin
            if (!out_valid_ff || rsp_ready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // result word holding register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         max_steps_ff <= MAX_STEPS_RESET;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid) begin
            max_steps_ff <= csr_max_steps;
         end
      end
   end

   // counter and result payload
   always_ff @(posedge clock) begin
      count_ff <= count_in;
      if (out_load) begin
         out_count_ff <= count_ff;
      end
   end

endmodule

// ===== rtl/mandelbrot_escape_count.sv =====
// mandelbrot_escape_count: escape-time counter for one point with a box escape test
// an accepted request runs i iterations, where i is the escape count plus one on escape, else
// max_steps, and 0 for a zero limit; each iteration is a product step then an add step
// a new point is accepted only once the previous result has moved into the response register
// reset: synchronous, clears the sequencer and response valid and sets max_steps to 20
module mandelbrot_escape_count
   import mec_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic signed [Z_W-1:0] req_c_real,
   input  logic signed [Z_W-1:0] req_c_imag,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [STEP_BITS-1:0]  rsp_step_count,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [STEP_BITS-1:0]  csr_max_steps
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencer and counter
   mec_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_step_count (rsp_step_count),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_max_steps  (csr_max_steps),
      .cmd            (cmd),
      .status         (status)
   );

   // iteration arithmetic
   mec_datapath u_datapath (
      .clock  (clock),
      .cmd    (cmd),
      .c_real (req_c_real),
      .c_imag (req_c_imag),
      .status (status)
   );

endmodule

// ===== rtl/mec_checker.sv =====
// mec_checker: port-level assertions for mandelbrot_escape_count, bound to the top level
// depends on mec_pkg
module mec_checker
   import mec_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [STEP_BITS-1:0]  rsp_step_count,
   input logic                  csr_valid,
   input logic                  csr_ready,
   input logic [STEP_BITS-1:0]  csr_max_steps
);

   logic [STEP_BITS-1:0] limit_ff;

   // shadow copy of the limit as seen on the config port
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= MAX_STEPS_RESET;
      end else if (csr_valid && csr_ready) begin
         limit_ff <= csr_max_steps;
      end
   end

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_step_count))
      else $error("response word changed while stalled");

   // the count never exceeds the limit
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_step_count <= limit_ff)
      else $error("step count above limit");

   // one point at a time: no request taken right after one was taken
   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // a response never appears the cycle after a request from an empty output
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("response too early");

endmodule

bind mandelbrot_escape_count mec_checker u_mec_checker (.*);

// ===== tb/sv/mec_escape_checker.sv =====
// mec_escape_checker: watches the request, response and csr channels of the escape counter,
// predicts each step count and compares it with the response word
// depends on mec_pkg for widths and the reset limit
module mec_escape_checker
   import mec_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic signed [Z_W-1:0] req_c_real,
   input  logic signed [Z_W-1:0] req_c_imag,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [STEP_BITS-1:0]  rsp_step_count,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [STEP_BITS-1:0]  csr_max_steps,
   output int                    fail_count,
   output int                    outstanding
);

   logic [STEP_BITS-1:0] step_limit;
   logic [STEP_BITS-1:0] expected_counts[$];
   logic [STEP_BITS-1:0] expected;

   // iterate z = z*z + c from z = c with truncating products and the box test
   function automatic logic [STEP_BITS-1:0] escape_steps(
      input logic signed [Z_W-1:0] c_re,
      input logic signed [Z_W-1:0] c_im,
      input logic [STEP_BITS-1:0]  limit
   );
      longint      cr, ci, zr, zi, rr, ii, ri;
      longint      re_bound, im_bound;
      int unsigned n;
      bit          gone;
      cr       = c_re;
      ci       = c_im;
      re_bound = longint'(2) <<< FRAC_BITS;
      im_bound = longint'(3) <<< (FRAC_BITS - 1);
      zr       = cr;
      zi       = ci;
      n        = 0;
      gone     = 1'b0;
      while (!gone && n < limit) begin
         rr = (zr * zr) >>> FRAC_BITS;
         ii = (zi * zi) >>> FRAC_BITS;
         ri = (zr * zi) >>> FRAC_BITS;
         zr = rr - ii + cr;
         zi = 2 * ri + ci;
         // bounds are inclusive, so only strictly outside counts as escape
         if (zr < -re_bound || zr > re_bound || zi < -im_bound || zi > im_bound)
            gone = 1'b1;
         else
            n++;
      end
      return n[STEP_BITS-1:0];
   endfunction

   // track the limit, queue predictions, compare response words in order
   always @(posedge clock) begin
      if (reset) begin
         step_limit = MAX_STEPS_RESET;
         expected_counts.delete();
         fail_count  = 0;
         outstanding = 0;
      end else begin
         if (csr_valid && csr_ready)
            step_limit = csr_max_steps;
         if (req_valid && req_ready)
            expected_counts.push_back(escape_steps(req_c_real, req_c_imag, step_limit));
         if (rsp_valid && rsp_ready) begin
            if (expected_counts.size() == 0) begin
               $error("step_count: unexpected word, expected none, got %0d", rsp_step_count);
               fail_count++;
            end else begin
               expected = expected_counts.pop_front();
               if (rsp_step_count !== expected) begin
                  $error("step_count mismatch: expected %0d, got %0d", expected,
                         rsp_step_count);
                  fail_count++;
               end
            end
         end
         outstanding = expected_counts.size();
      end
   end

endmodule

// ===== tb/sv/tb_mandelbrot_escape_count.sv =====
// tb_mandelbrot_escape_count: stimulus, flow control and verdict for the escape counter
// depends on mec_pkg, mandelbrot_escape_count and mec_escape_checker
module tb_mandelbrot_escape_count;
   import mec_pkg::*;

   // one in Q5.27 and a few landmarks of the box
   localparam int ONE      = 1 << FRAC_BITS;
   localparam int TWO      = 2 * ONE;
   localparam int ONE_HALF = 3 * (ONE / 2);
   // window that covers the set with a small margin
   localparam int RE_MIN   = -281857229;
   localparam int RE_SPAN  = 362387866;
   localparam int IM_MAX   = 174483046;
   // long response hold-off, and the word count at which it starts
   localparam int HOLD_CYCLES = 400;
   localparam int HOLD_AT     = 700;
   localparam int WATCHDOG_LIMIT = 400000;
   localparam int RANDOM_PHASES  = 6;
   localparam int PHASE_POINTS   = 230;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic signed [Z_W-1:0] req_c_real;
   logic signed [Z_W-1:0] req_c_imag;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [STEP_BITS-1:0]  rsp_step_count;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [STEP_BITS-1:0]  csr_max_steps;
   int                    fail_count;
   int                    outstanding;
   bit                    steady;

   mandelbrot_escape_count dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_c_real     (req_c_real),
      .req_c_imag     (req_c_imag),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_step_count (rsp_step_count),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_max_steps  (csr_max_steps)
   );

   mec_escape_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_c_real     (req_c_real),
      .req_c_imag     (req_c_imag),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_step_count (rsp_step_count),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_max_steps  (csr_max_steps),
      .fail_count     (fail_count),
      .outstanding    (outstanding)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // offer one point after a random gap, hold it until accepted
   task automatic offer_point(input logic signed [Z_W-1:0] re, input logic signed [Z_W-1:0] im);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 9);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_c_real <= re;
      req_c_imag <= im;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   // wait until every word is back, then write the iteration limit
   task automatic set_step_limit(input logic [STEP_BITS-1:0] limit);
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      csr_valid     <= 1'b1;
      csr_max_steps <= limit;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // mostly points near the set, some anywhere, some hugging the box edges
   task automatic draw_point(output logic signed [Z_W-1:0] re,
                             output logic signed [Z_W-1:0] im);
      int kind;
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
         re = Z_W'($urandom);
         im = Z_W'($urandom);
      end else if (kind < 9) begin
         re = Z_W'(RE_MIN + int'($urandom_range(0, RE_SPAN)));
         im = Z_W'(int'($urandom_range(0, 2 * IM_MAX)) - IM_MAX);
      end else begin
         re = Z_W'(($urandom_range(0, 1) ? TWO : -TWO) + int'($urandom_range(0, 64)) - 32);
         im = Z_W'(int'($urandom_range(0, 2 * ONE_HALF)) - ONE_HALF);
      end
   endtask

   task automatic run_points(input int count);
      logic signed [Z_W-1:0] re, im;
      repeat (count) begin
         draw_point(re, im);
         offer_point(re, im);
      end
   endtask

   // response side: random gaps, one long hold-off while requests keep coming
   initial begin : receive
      int gap;
      int words;
      rsp_ready = 1'b0;
      words     = 0;
      forever begin
         gap = steady ? 0 : $urandom_range(0, 9);
         if (words == HOLD_AT)
            gap = HOLD_CYCLES;
         @(negedge clock);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         words++;
      end
   end

   // watchdog on cycles with no word accepted anywhere
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
             || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // stimulus and verdict
   initial begin : stimulus
      int phase;
      clock         = 1'b0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_c_real    = '0;
      req_c_imag    = '0;
      csr_valid     = 1'b0;
      csr_max_steps = '0;
      steady        = 1'b0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // reset limit: fixed points, cycles, box edges, extremes, truncation
      offer_point(0, 0);
      offer_point(-TWO, 0);
      offer_point(TWO, 0);
      offer_point(-TWO - 1, 0);
      offer_point(0, ONE);
      offer_point(0, ONE_HALF);
      offer_point(-ONE, 0);
      offer_point(ONE / 4, 0);
      offer_point(ONE / 4 + ONE / 64, 0);
      offer_point(ONE / 2, ONE / 2);
      offer_point(-1, -1);
      offer_point(-3, 5);
      offer_point(3 * ONE, 0);
      offer_point(32'sh8000_0000, 32'sh8000_0000);
      offer_point(32'sh7fff_ffff, 32'sh7fff_ffff);
      offer_point(32'sh8000_0000, 32'sh7fff_ffff);
      offer_point(32'sh7fff_ffff, 32'sh8000_0000);

      // zero limit
      set_step_limit(16'd0);
      offer_point(0, 0);
      run_points(12);

      // limit of one
      set_step_limit(16'd1);
      offer_point(0, 0);
      offer_point(TWO, 0);
      offer_point(-TWO, 0);
      run_points(15);

      // largest limit: two points that never escape, the rest leave fast
      set_step_limit(16'hffff);
      offer_point(0, 0);
      offer_point(-TWO, 0);
      offer_point(TWO, ONE_HALF);
      repeat (10) offer_point(Z_W'($urandom), Z_W'($urandom));

      // random limits, the reset limit in the last phase; one phase runs with no gaps on either side
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == RANDOM_PHASES - 1)
            set_step_limit(MAX_STEPS_RESET);
         else
            set_step_limit(STEP_BITS'($urandom_range(2, 100)));
         steady = (phase == 2);
         run_points(PHASE_POINTS);
      end
      steady = 1'b0;

      // drain, then give any stray word time to show up
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (2 * int'(MAX_STEPS_RESET) + 20) @(negedge clock);

      if (fail_count == 0 && outstanding == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
